FILE: sv/cft_pkg.sv
// package: shared codes, field widths and pipeline tag type for the frustum cull tester
`timescale 1ns / 1ps
`default_nettype none
package cft_pkg;

  localparam int FUNC_W   = 2;
  localparam int IDX_W    = 3;
  localparam int FIELD_W  = 32;
  localparam int MARGIN_W = 16;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // request kinds carried on in_tuser
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SPHERE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_BOX    = 2'd2;

  // register index as selected by the address word
  localparam logic REG_MARGIN = 1'b0;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd66;

  typedef struct packed {
    logic vld;
    logic last;
  } cft_tag_t;

endpackage
`default_nettype wire

FILE: sv/cft_plane_mem.sv
// plane store: one row per plane, synchronous read, valid bits for reset-to-zero
`timescale 1ns / 1ps
`default_nettype none
module cft_plane_mem
  import cft_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int NUM_PLANES = 6,
  parameter int ADDR_W     = 3
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      wr_en,
  input  wire [ADDR_W-1:0]         wr_addr,
  input  wire [4*COORD_BITS-1:0]   wr_row,
  input  wire                      rd_en,
  input  wire [ADDR_W-1:0]         rd_addr,
  input  cft_tag_t                 rd_tag,
  output logic [4*COORD_BITS-1:0] rd_row,
  output cft_tag_t                 rd_tag_out
);

  logic [4*COORD_BITS-1:0] mem [NUM_PLANES];
  logic [NUM_PLANES-1:0]   row_vld_r;
  logic [4*COORD_BITS-1:0] rd_data_r;
  logic                    rd_vld_r;
  cft_tag_t                rd_tag_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      rd_tag_r  <= '0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
      rd_tag_r <= rd_en ? rd_tag : '0;
    end
  end

  // a row never loaded reads as zero
  assign rd_row     = rd_vld_r ? rd_data_r : '0;
  assign rd_tag_out = rd_tag_r;

endmodule
`default_nettype wire

FILE: sv/cft_dot_unit.sv
// shared plane distance unit: vertex select, three products, offset sum and sign
`timescale 1ns / 1ps
`default_nettype none
module cft_dot_unit
  import cft_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  cft_tag_t                      tag_in,
  input  wire [4*COORD_BITS-1:0]        row,
  input  wire signed [COORD_BITS-1:0]   first_x,
  input  wire signed [COORD_BITS-1:0]   first_y,
  input  wire signed [COORD_BITS-1:0]   first_z,
  input  wire signed [COORD_BITS-1:0]   second_x,
  input  wire signed [COORD_BITS-1:0]   second_y,
  input  wire signed [COORD_BITS-1:0]   second_z,
  input  wire signed [COORD_BITS-1:0]   scalar,
  input  wire [MARGIN_W-1:0]            margin,
  input  wire                           is_box,
  output cft_tag_t                      tag_out,
  output logic                          outside
);

  localparam int PROD_W = 2 * COORD_BITS;
  localparam int OFF_W  = ((COORD_BITS > MARGIN_W) ? COORD_BITS : MARGIN_W + 1) + 2;
  localparam int SH_W   = OFF_W + FRAC_BITS;
  localparam int SUM_W  = ((PROD_W > SH_W) ? PROD_W : SH_W) + 3;

  logic signed [COORD_BITS-1:0] nx, ny, nz, w;
  logic signed [COORD_BITS-1:0] vx, vy, vz;
  logic signed [COORD_BITS-1:0] extra_sc;
  logic signed [MARGIN_W:0]     margin_s;
  logic signed [PROD_W-1:0]     px_nxt, py_nxt, pz_nxt;
  logic signed [PROD_W-1:0]     px_r, py_r, pz_r;
  logic signed [OFF_W-1:0]      off_nxt, off_r;
  logic signed [SUM_W-1:0]      plane_dist;
  cft_tag_t                     tag_r;

  assign nx = row[COORD_BITS-1:0];
  assign ny = row[2*COORD_BITS-1:COORD_BITS];
  assign nz = row[3*COORD_BITS-1:2*COORD_BITS];
  assign w  = row[4*COORD_BITS-1:3*COORD_BITS];

  // positive vertex: box max on axes with a strictly positive normal component
  assign vx = (is_box && !nx[COORD_BITS-1] && (nx != '0)) ? second_x : first_x;
  assign vy = (is_box && !ny[COORD_BITS-1] && (ny != '0)) ? second_y : first_y;
  assign vz = (is_box && !nz[COORD_BITS-1] && (nz != '0)) ? second_z : first_z;

  assign extra_sc = is_box ? '0 : scalar;
  assign margin_s = $signed({1'b0, margin});

  assign px_nxt  = PROD_W'(nx) * PROD_W'(vx);
  assign py_nxt  = PROD_W'(ny) * PROD_W'(vy);
  assign pz_nxt  = PROD_W'(nz) * PROD_W'(vz);
  assign off_nxt = OFF_W'(w) + OFF_W'(extra_sc) + OFF_W'(margin_s);

  always_ff @(posedge clk) begin
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    pz_r  <= pz_nxt;
    off_r <= off_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
  end

  assign plane_dist = SUM_W'(px_r) + SUM_W'(py_r) + SUM_W'(pz_r)
                    + (SUM_W'(off_r) <<< FRAC_BITS);

  assign outside = plane_dist[SUM_W-1];
  assign tag_out = tag_r;

endmodule
`default_nettype wire

FILE: sv/frustum_cull_tester.sv
// frustum cull tester: plane store, one shared distance unit, APB margin register
//
// Input channel in_*: one request per handshake. in_tuser holds the kind: load
// plane, sphere test or box test. A load writes the plane named by plane_index
// (indexes at or above NUM_PLANES are dropped) and gives no result; kind 3 is
// dropped as well. A test gives one result on out_*: out_tdata[0] is 1 when the
// object is visible, 0 when some plane culls it.
// A test reads one plane row per cycle from the plane memory, whose single read
// port sets the rate. The result becomes valid in the same cycle in which
// in_tready goes high again. in_tready is low while a test is in progress.
// The result sits in an output register. If the receiver stalls, a later test
// finishes and waits inside the block until that register is taken.
// Reset (rst_n low, synchronous) clears all planes to zero and sets margin to 66.
// margin is written over APB at byte address 0 and should change only while idle.
`timescale 1ns / 1ps
`default_nettype none
module frustum_cull_tester
  import cft_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  parameter int NUM_PLANES = 6
) (
  input  wire                clk,
  input  wire                rst_n,
  // in_tdata, low bit up: plane_index, first_x, first_y, first_z,
  // second_x, second_y, second_z, scalar, zero pad
  input  wire                in_tvalid,
  output logic               in_tready,
  input  wire [231:0]        in_tdata,
  // in_tuser: func
  input  wire [FUNC_W-1:0]   in_tuser,
  output logic               out_tvalid,
  input  wire                out_tready,
  // out_tdata, low bit up: visible, zero pad
  output logic [7:0]         out_tdata,
  input  wire                cfg_psel,
  input  wire                cfg_penable,
  input  wire                cfg_pwrite,
  input  wire [APB_AW-1:0]   cfg_paddr,
  input  wire [APB_DW-1:0]   cfg_pwdata,
  output logic [APB_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  localparam int ADDR_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(NUM_PLANES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  // request fields
  logic [IDX_W-1:0]             plane_index;
  logic signed [FIELD_W-1:0]    f_fx, f_fy, f_fz, f_sx, f_sy, f_sz, f_sc;
  logic signed [COORD_BITS-1:0] c_fx, c_fy, c_fz, c_sx, c_sy, c_sz, c_sc;

  assign plane_index = in_tdata[2:0];
  assign f_fx = in_tdata[34:3];
  assign f_fy = in_tdata[66:35];
  assign f_fz = in_tdata[98:67];
  assign f_sx = in_tdata[130:99];
  assign f_sy = in_tdata[162:131];
  assign f_sz = in_tdata[194:163];
  assign f_sc = in_tdata[226:195];

  // sign-extend or wrap each field to the coordinate width
  assign c_fx = COORD_BITS'(f_fx);
  assign c_fy = COORD_BITS'(f_fy);
  assign c_fz = COORD_BITS'(f_fz);
  assign c_sx = COORD_BITS'(f_sx);
  assign c_sy = COORD_BITS'(f_sy);
  assign c_sz = COORD_BITS'(f_sz);
  assign c_sc = COORD_BITS'(f_sc);

  logic [1:0]                   state_r, state_nxt;
  logic [ADDR_W-1:0]            rd_cnt_r, rd_cnt_nxt;
  logic                         issue_r, issue_nxt;
  logic                         acc_r, acc_nxt;
  logic                         hold_vis_r, hold_vis_nxt;
  logic                         out_vld_r, out_vld_nxt;
  logic                         out_vis_r, out_vis_nxt;
  logic [MARGIN_W-1:0]          margin_r;
  logic signed [COORD_BITS-1:0] fx_r, fy_r, fz_r, sx_r, sy_r, sz_r, sc_r;
  logic                         is_box_r;

  logic        in_acc;
  logic        is_test;
  logic        mem_wr;
  logic        mem_rd;
  cft_tag_t    rd_tag;
  cft_tag_t    mem_tag;
  cft_tag_t    dot_tag;
  logic [4*COORD_BITS-1:0] mem_row;
  logic        outside;
  logic        out_free;
  logic        final_vis;
  logic        cfg_wr;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_test   = (in_tuser == FUNC_SPHERE) || (in_tuser == FUNC_BOX);
  // one extra bit so that a full set of eight planes still compares correctly
  assign mem_wr    = in_acc && (in_tuser == FUNC_LOAD) &&
                     ({1'b0, plane_index} < (IDX_W + 1)'(NUM_PLANES));
  assign mem_rd    = (state_r == ST_RUN) && issue_r;
  assign rd_tag.vld  = mem_rd;
  assign rd_tag.last = (rd_cnt_r == LAST_ROW);
  assign out_free  = !out_vld_r || out_tready;
  assign final_vis = acc_r && !outside;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fx_r     <= c_fx;
      fy_r     <= c_fy;
      fz_r     <= c_fz;
      sx_r     <= c_sx;
      sy_r     <= c_sy;
      sz_r     <= c_sz;
      sc_r     <= c_sc;
      is_box_r <= (in_tuser == FUNC_BOX);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    rd_cnt_nxt   = rd_cnt_r;
    issue_nxt    = issue_r;
    acc_nxt      = acc_r;
    hold_vis_nxt = hold_vis_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_vis_nxt  = out_vis_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && is_test) begin
          state_nxt  = ST_RUN;
          rd_cnt_nxt = '0;
          issue_nxt  = 1'b1;
          acc_nxt    = 1'b1;
        end
      end
      ST_RUN: begin
        if (mem_rd) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
          if (rd_tag.last) begin
            issue_nxt = 1'b0;
          end
        end
        if (dot_tag.vld) begin
          acc_nxt = final_vis;
          if (dot_tag.last) begin
            if (out_free) begin
              out_vld_nxt = 1'b1;
              out_vis_nxt = final_vis;
              state_nxt   = ST_IDLE;
            end else begin
              hold_vis_nxt = final_vis;
              state_nxt    = ST_HOLD;
            end
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_vis_nxt = hold_vis_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rd_cnt_r   <= '0;
      issue_r    <= 1'b0;
      acc_r      <= 1'b1;
      hold_vis_r <= 1'b0;
      out_vld_r  <= 1'b0;
      out_vis_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      issue_r    <= issue_nxt;
      acc_r      <= acc_nxt;
      hold_vis_r <= hold_vis_nxt;
      out_vld_r  <= out_vld_nxt;
      out_vis_r  <= out_vis_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_vis_r};

  // apb register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_MARGIN)) begin
      margin_r <= cfg_pwdata[MARGIN_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_MARGIN) ? APB_DW'(margin_r) : '0;

  cft_plane_mem #(
    .COORD_BITS (COORD_BITS),
    .NUM_PLANES (NUM_PLANES),
    .ADDR_W     (ADDR_W)
  ) u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (mem_wr),
    .wr_addr    (plane_index[ADDR_W-1:0]),
    .wr_row     ({c_sc, c_fz, c_fy, c_fx}),
    .rd_en      (mem_rd),
    .rd_addr    (rd_cnt_r),
    .rd_tag     (rd_tag),
    .rd_row     (mem_row),
    .rd_tag_out (mem_tag)
  );

  cft_dot_unit #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (mem_tag),
    .row      (mem_row),
    .first_x  (fx_r),
    .first_y  (fy_r),
    .first_z  (fz_r),
    .second_x (sx_r),
    .second_y (sy_r),
    .second_z (sz_r),
    .scalar   (sc_r),
    .margin   (margin_r),
    .is_box   (is_box_r),
    .tag_out  (dot_tag),
    .outside  (outside)
  );

  // a plane load never lands while a test is reading rows
  a_no_wr_during_rd: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr && mem_rd))
    else $error("plane write overlaps a row read");

  a_test_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_test) |=> (state_r == ST_RUN) && issue_r && (rd_cnt_r == '0))
    else $error("accepted test did not start the row sweep");

  a_last_row_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (dot_tag.vld && dot_tag.last) |=> (state_r == ST_IDLE) || (state_r == ST_HOLD))
    else $error("test still running after its last plane");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(dot_tag.vld && dot_tag.last) || $past(state_r == ST_HOLD))
    else $error("result produced without a finished test");

  a_pipe_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_tag.vld && !dot_tag.vld)
    else $error("plane rows in flight while idle");

endmodule
`default_nettype wire
